// ===== src/frame_buffer_pool_manager_top_macros.svh =====
// ----------------------------------------------------------------------------
// Frame buffer pool manager assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FRAME_BUFFER_POOL_MANAGER_TOP_MACROS_SVH
`define FRAME_BUFFER_POOL_MANAGER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define FBPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define FBPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fbpm_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame buffer pool manager package
// Shared widths, request codes and defaults for the pool manager.
// ----------------------------------------------------------------------------
package fbpm_pkg;

  // Fixed field widths of a request and a result word.
  localparam int ID_W   = 4;
  localparam int LVL_W  = 5;
  localparam int MODE_W = 2;

  // Default pool size.
  localparam int NUM_BUFFERS_DEF = 16;

  // Request codes.
  typedef enum logic [MODE_W-1:0] {
    MODE_GET     = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_STORE   = 2'd2,
    MODE_LOAD    = 2'd3
  } mode_t;

endpackage

// ===== src/fbpm_if.sv =====
// ----------------------------------------------------------------------------
// Frame buffer pool manager channels
// Request and result channels with a valid/ready handshake.
// ----------------------------------------------------------------------------

// Request channel: one word carries a request code and a buffer id.
interface fbpm_in_if;
  logic                        valid;
  logic                        ready;
  logic [fbpm_pkg::MODE_W-1:0] mode;
  logic [fbpm_pkg::ID_W-1:0]   buffer_id;

  modport source (output valid, output mode, output buffer_id, input ready);
  modport sink   (input valid, input mode, input buffer_id, output ready);
endinterface

// Result channel: one word per request.
interface fbpm_out_if;
  logic                       valid;
  logic                       ready;
  logic [fbpm_pkg::ID_W-1:0]  out_id;
  logic                       got_buffer;
  logic                       dropped_oldest;
  logic                       overflow_error;
  logic [fbpm_pkg::LVL_W-1:0] free_level;
  logic [fbpm_pkg::LVL_W-1:0] ready_level;

  modport source (output valid, output out_id, output got_buffer, output dropped_oldest,
                  output overflow_error, output free_level, output ready_level,
                  input ready);
  modport sink   (input valid, input out_id, input got_buffer, input dropped_oldest,
                  input overflow_error, input free_level, input ready_level,
                  output ready);
endinterface

// ===== src/fbpm_free_stack.sv =====
// ----------------------------------------------------------------------------
// Free id stack memory
// Synchronous memory holding the free ids, with one valid bit per entry so
// that an entry never written reads back as its own index.
// ----------------------------------------------------------------------------
module fbpm_free_stack #(
  parameter int NUM_BUFFERS = fbpm_pkg::NUM_BUFFERS_DEF,
  localparam int AW = $clog2(NUM_BUFFERS)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [fbpm_pkg::ID_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [fbpm_pkg::ID_W-1:0] wr_data
);

  logic [fbpm_pkg::ID_W-1:0] mem_r [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0]    vld_r;
  logic [fbpm_pkg::ID_W-1:0] rd_data_r;
  logic                      rd_vld_r;
  logic [AW-1:0]             rd_addr_r;

  // Memory write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Entry valid bits: cleared by reset, set on the first write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read port; the address is kept for the reset value.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  // An entry never written holds its own index as an id.
  assign rd_data = rd_vld_r ? rd_data_r : fbpm_pkg::ID_W'(rd_addr_r);

endmodule

// ===== src/fbpm_ready_queue.sv =====
// ----------------------------------------------------------------------------
// Ready frame queue memory
// Synchronous circular buffer storage for the ids of filled frames.
// ----------------------------------------------------------------------------
module fbpm_ready_queue #(
  parameter int NUM_BUFFERS = fbpm_pkg::NUM_BUFFERS_DEF,
  localparam int AW = $clog2(NUM_BUFFERS)
) (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [fbpm_pkg::ID_W-1:0] rd_data,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [fbpm_pkg::ID_W-1:0] wr_data
);

  logic [fbpm_pkg::ID_W-1:0] mem_r [NUM_BUFFERS];
  logic [fbpm_pkg::ID_W-1:0] rd_data_r;

  // Memory write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/frame_buffer_pool_manager_top.sv =====
// ----------------------------------------------------------------------------
// Frame buffer pool manager
// Hands out frame buffer ids from a last-in-first-out free stack and keeps
// filled frames in a first-in-first-out ready queue; every request word
// gives exactly one result word. A get pops the free stack, or takes the
// oldest ready frame and flags the drop when the stack is empty; a release
// pushes onto the stack, a store appends to the queue and a load takes the
// oldest frame. A release onto a full stack or a store into a full queue
// flags an overflow and changes nothing. In the cycle a request is accepted
// the stack top and the queue head are read from their synchronous
// memories; in the update state that follows, the counters are updated, any
// write goes back to memory and the result word is loaded into the output
// register. A held result stalls the update state, and no new request is
// taken until the current one is through. Ids are 4 bits and the levels are
// reported modulo 32. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module frame_buffer_pool_manager_top #(
  parameter int NUM_BUFFERS = fbpm_pkg::NUM_BUFFERS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  fbpm_in_if.sink    in_if,
  fbpm_out_if.source out_if
);

  localparam int AW = $clog2(NUM_BUFFERS);
  localparam int CW = $clog2(NUM_BUFFERS + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                    state_r, state_nxt;
  fbpm_pkg::mode_t           mode_r;
  logic [fbpm_pkg::ID_W-1:0] id_r;
  logic [CW-1:0]             free_cnt_r, free_cnt_nxt;
  logic [CW-1:0]             rdy_cnt_r, rdy_cnt_nxt;
  logic [AW-1:0]             head_r, head_nxt;
  logic [AW-1:0]             tail_r, tail_nxt;

  logic                      in_acc;
  logic                      exec_go;
  logic                      st_wr_en;
  logic                      q_wr_en;
  logic [fbpm_pkg::ID_W-1:0] st_rd_data;
  logic [fbpm_pkg::ID_W-1:0] q_rd_data;

  logic [fbpm_pkg::ID_W-1:0] res_id;
  logic                      res_got;
  logic                      res_drop;
  logic                      res_ovf;

  logic                       out_valid_r;
  logic [fbpm_pkg::ID_W-1:0]  out_id_r;
  logic                       got_r;
  logic                       drop_r;
  logic                       ovf_r;
  logic [fbpm_pkg::LVL_W-1:0] free_lvl_r;
  logic [fbpm_pkg::LVL_W-1:0] rdy_lvl_r;

  // Handshakes: a request is taken only between updates, and the update
  // waits while the output register still holds an untaken word.
  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign exec_go     = (state_r == S_EXEC) && (!out_valid_r || out_if.ready);

  // Stack and queue memories. Both are read in the accept cycle; writes land
  // in the update cycle, so a read never meets a write to the same entry.
  fbpm_free_stack #(.NUM_BUFFERS(NUM_BUFFERS)) u_free_stack (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (AW'(free_cnt_r - 1'b1)),
    .rd_data (st_rd_data),
    .wr_en   (st_wr_en),
    .wr_addr (AW'(free_cnt_r)),
    .wr_data (id_r)
  );

  fbpm_ready_queue #(.NUM_BUFFERS(NUM_BUFFERS)) u_ready_queue (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (head_r),
    .rd_data (q_rd_data),
    .wr_en   (q_wr_en),
    .wr_addr (tail_r),
    .wr_data (id_r)
  );

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= fbpm_pkg::mode_t'(in_if.mode);
      id_r   <= in_if.buffer_id;
    end
  end

  // Sequencer and pointer update.
  always_comb begin
    state_nxt    = state_r;
    free_cnt_nxt = free_cnt_r;
    rdy_cnt_nxt  = rdy_cnt_r;
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    st_wr_en     = 1'b0;
    q_wr_en      = 1'b0;
    res_id       = '0;
    res_got      = 1'b0;
    res_drop     = 1'b0;
    res_ovf      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_nxt = S_IDLE;
          unique case (mode_r)
            fbpm_pkg::MODE_GET: begin
              if (free_cnt_r != '0) begin
                free_cnt_nxt = free_cnt_r - 1'b1;
                res_id       = st_rd_data;
                res_got      = 1'b1;
              end else if (rdy_cnt_r != '0) begin
                rdy_cnt_nxt = rdy_cnt_r - 1'b1;
                head_nxt    = (head_r == AW'(NUM_BUFFERS - 1)) ? '0 : head_r + 1'b1;
                res_id      = q_rd_data;
                res_got     = 1'b1;
                res_drop    = 1'b1;
              end
            end
            fbpm_pkg::MODE_RELEASE: begin
              if (free_cnt_r == CW'(NUM_BUFFERS)) begin
                res_ovf = 1'b1;
              end else begin
                st_wr_en     = 1'b1;
                free_cnt_nxt = free_cnt_r + 1'b1;
              end
            end
            fbpm_pkg::MODE_STORE: begin
              if (rdy_cnt_r == CW'(NUM_BUFFERS)) begin
                res_ovf = 1'b1;
              end else begin
                q_wr_en     = 1'b1;
                rdy_cnt_nxt = rdy_cnt_r + 1'b1;
                tail_nxt    = (tail_r == AW'(NUM_BUFFERS - 1)) ? '0 : tail_r + 1'b1;
              end
            end
            fbpm_pkg::MODE_LOAD: begin
              if (rdy_cnt_r != '0) begin
                rdy_cnt_nxt = rdy_cnt_r - 1'b1;
                head_nxt    = (head_r == AW'(NUM_BUFFERS - 1)) ? '0 : head_r + 1'b1;
                res_id      = q_rd_data;
                res_got     = 1'b1;
              end
            end
            default: begin
              res_id = '0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      free_cnt_r <= CW'(NUM_BUFFERS);
      rdy_cnt_r  <= '0;
      head_r     <= '0;
      tail_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      free_cnt_r <= free_cnt_nxt;
      rdy_cnt_r  <= rdy_cnt_nxt;
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
    end
  end

  // Output word valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output word payload, levels as they stand after the request.
  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_id_r   <= res_id;
      got_r      <= res_got;
      drop_r     <= res_drop;
      ovf_r      <= res_ovf;
      free_lvl_r <= fbpm_pkg::LVL_W'(free_cnt_nxt);
      rdy_lvl_r  <= fbpm_pkg::LVL_W'(rdy_cnt_nxt);
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.out_id         = out_id_r;
  assign out_if.got_buffer     = got_r;
  assign out_if.dropped_oldest = drop_r;
  assign out_if.overflow_error = ovf_r;
  assign out_if.free_level     = free_lvl_r;
  assign out_if.ready_level    = rdy_lvl_r;

endmodule

// ===== src/fbpm_checker.sv =====
// ----------------------------------------------------------------------------
// Frame buffer pool manager port checker
// Concurrent checks on the request and result ports, bound to the top level.
// ----------------------------------------------------------------------------
`include "frame_buffer_pool_manager_top_macros.svh"

module fbpm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [fbpm_pkg::ID_W-1:0]  out_id,
  input logic                       got_buffer,
  input logic                       dropped_oldest,
  input logic                       overflow_error,
  input logic [fbpm_pkg::LVL_W-1:0] free_level
);

  // A result word stays offered until it is taken.
  `FBPM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result word withdrawn")

  // Each request holds the block busy for its update cycle.
  `FBPM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "request taken while busy")

  // A drop only happens on a handout with the free stack empty.
  `FBPM_ASSERT_NOW(a_drop_cause, out_valid && dropped_oldest, got_buffer && free_level == '0, "drop without empty free stack")

  // No handout means a zero id and no drop.
  `FBPM_ASSERT_NOW(a_no_buffer_zero, out_valid && !got_buffer, out_id == '0 && !dropped_oldest, "id or drop without handout")

  // An overflow never hands out a buffer.
  `FBPM_ASSERT_NOW(a_ovf_no_handout, out_valid && overflow_error, !got_buffer, "overflow with handout")

endmodule

bind frame_buffer_pool_manager_top fbpm_checker u_fbpm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .out_id         (out_if.out_id),
  .got_buffer     (out_if.got_buffer),
  .dropped_oldest (out_if.dropped_oldest),
  .overflow_error (out_if.overflow_error),
  .free_level     (out_if.free_level)
);
